### rtl/core/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants, codes and pointer helpers for the stereo frame ring.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int SAMPLE_W   = 20;
    localparam int FRAME_W    = 2 * SAMPLE_W;
    localparam int BLOCK_W    = 11;
    localparam int LEVEL_W    = 10;
    localparam int FILL_W     = (PTR_W > LEVEL_W) ? PTR_W : LEVEL_W;
    localparam int CMP_W      = (PTR_W + 1 > BLOCK_W) ? PTR_W + 1 : BLOCK_W;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    localparam logic [2:0] CMD_FILE_PUSH   = 3'd0;
    localparam logic [2:0] CMD_MIX_READ    = 3'd1;
    localparam logic [2:0] CMD_RECORD_PUSH = 3'd2;
    localparam logic [2:0] CMD_DRAIN_READ  = 3'd3;
    localparam logic [2:0] CMD_RESTART     = 3'd4;

    localparam logic [1:0] MODE_PLAY   = 2'd1;
    localparam logic [1:0] MODE_RECORD = 2'd2;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_MONO = 2'd1;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] fill_of(input logic [PTR_W-1:0] w,
                                                 input logic [PTR_W-1:0] r);
        logic [PTR_W:0] t;
        if (w >= r) begin
            t = {1'b0, w} - {1'b0, r};
        end else begin
            t = {1'b0, w} + (PTR_W + 1)'(RING_DEPTH) - {1'b0, r};
        end
        return t[PTR_W-1:0];
    endfunction

    function automatic logic [LEVEL_W-1:0] level_of(input logic [PTR_W-1:0] f);
        logic [FILL_W-1:0] t;
        t = FILL_W'(f);
        return t[LEVEL_W-1:0];
    endfunction

endpackage

### rtl/core/stereo_frame_ring_with_conversion.sv
// ----------------------------------------------------------------------------
// stereo_frame_ring_with_conversion
// Stereo frame ring between a file side and an audio side with Q4.15 mix,
// record admission by block length, and int16 drain conversion.
// ----------------------------------------------------------------------------
// Result path: pushes, refused commands and restart register their result
// directly; mix and drain reads first pass the memory read register (ST_READ).
// Throughput: one item per cycle for pushes, refused commands and restart
// while the output is not stalled; a read that takes a frame blocks the
// next command until its memory read has completed.
// Reset: pointers, underrun flag, mode and mono cleared; frame memory is not
// cleared, so the block accepts items as soon as reset is released.
// ----------------------------------------------------------------------------
module stereo_frame_ring_with_conversion
    import sfr_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic        [1:0]          cfg_index,
    input  logic        [1:0]          cfg_data,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic        [2:0]          s_cmd,
    input  logic signed [SAMPLE_W-1:0] s_left_in,
    input  logic signed [SAMPLE_W-1:0] s_right_in,
    input  logic        [BLOCK_W-1:0]  s_block_left,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_accepted,
    output logic signed [SAMPLE_W-1:0] m_left_out,
    output logic signed [SAMPLE_W-1:0] m_right_out,
    output logic                       m_underrun_flag,
    output logic        [LEVEL_W-1:0]  m_fill_level
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic [FRAME_W-1:0] mem [RING_DEPTH];

    logic                       state_reg;
    logic [1:0]                 mode_reg;
    logic                       mono_reg;
    logic [PTR_W-1:0]           wr_ptr_reg;
    logic [PTR_W-1:0]           rd_ptr_reg;
    logic                       underrun_reg;
    logic [FRAME_W-1:0]         rd_data_reg;
    logic                       op_drain_reg;
    logic signed [SAMPLE_W-1:0] hold_left_reg;
    logic signed [SAMPLE_W-1:0] hold_right_reg;

    logic                       m_valid_reg;
    logic                       out_acc_reg;
    logic signed [SAMPLE_W-1:0] out_left_reg;
    logic signed [SAMPLE_W-1:0] out_right_reg;
    logic                       out_underrun_reg;
    logic [LEVEL_W-1:0]         out_level_reg;

    logic                       fire;
    logic [PTR_W-1:0]           fill;
    logic [CMP_W-1:0]           free_cnt;
    logic [CMP_W-1:0]           blk_need;
    logic                       do_push;
    logic                       do_read;
    logic                       acc;
    logic [FRAME_W-1:0]         push_data;
    logic signed [SAMPLE_W-1:0] res_left;
    logic signed [SAMPLE_W-1:0] res_right;
    logic [PTR_W-1:0]           wr_ptr_next;
    logic [PTR_W-1:0]           rd_ptr_next;
    logic                       underrun_next;
    logic signed [SAMPLE_W-1:0] file_left;
    logic signed [SAMPLE_W-1:0] file_right;
    logic signed [SAMPLE_W-1:0] conv_left;
    logic signed [SAMPLE_W-1:0] conv_right;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign fire      = s_valid && s_ready;

    assign fill     = fill_of(wr_ptr_reg, rd_ptr_reg);
    assign free_cnt = CMP_W'(RING_DEPTH - 1) - CMP_W'(fill);
    assign blk_need = (s_block_left == '0) ? CMP_W'(1) : CMP_W'(s_block_left);

    assign file_left  = SAMPLE_W'($signed(s_left_in[15:0]));
    assign file_right = mono_reg ? file_left : SAMPLE_W'($signed(s_right_in[15:0]));

    always_comb begin
        do_push       = 1'b0;
        do_read       = 1'b0;
        acc           = 1'b0;
        push_data     = {s_left_in, s_right_in};
        res_left      = '0;
        res_right     = '0;
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        underrun_next = underrun_reg;
        unique case (s_cmd)
            CMD_FILE_PUSH: begin
                push_data = {file_left, file_right};
                if (mode_reg == MODE_PLAY && fill != PTR_LAST) begin
                    do_push = 1'b1;
                end
            end
            CMD_MIX_READ: begin
                res_left  = s_left_in;
                res_right = s_right_in;
                if (mode_reg == MODE_PLAY) begin
                    if (fill == '0) begin
                        underrun_next = 1'b1;
                    end else begin
                        do_read = 1'b1;
                    end
                end
            end
            CMD_RECORD_PUSH: begin
                if (mode_reg == MODE_RECORD && free_cnt >= blk_need) begin
                    do_push = 1'b1;
                end
            end
            CMD_DRAIN_READ: begin
                if (mode_reg == MODE_RECORD && fill != '0) begin
                    do_read = 1'b1;
                end
            end
            CMD_RESTART: begin
                wr_ptr_next   = '0;
                rd_ptr_next   = '0;
                underrun_next = 1'b0;
            end
            default: begin
            end
        endcase
        if (do_push) begin
            acc         = 1'b1;
            wr_ptr_next = ptr_inc(wr_ptr_reg);
        end
        if (do_read) begin
            rd_ptr_next = ptr_inc(rd_ptr_reg);
        end
    end

    sfr_convert u_convert (
        .is_drain  (op_drain_reg),
        .mix_left  (hold_left_reg),
        .mix_right (hold_right_reg),
        .frame     (rd_data_reg),
        .left_out  (conv_left),
        .right_out (conv_right)
    );

    always_ff @(posedge aclk) begin
        if (fire && do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (fire && do_read) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= '0;
            mono_reg     <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            underrun_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_MODE) mode_reg <= cfg_data;
                if (cfg_index == REG_MONO) mono_reg <= cfg_data[0];
            end
            if (fire) begin
                wr_ptr_reg   <= wr_ptr_next;
                rd_ptr_reg   <= rd_ptr_next;
                underrun_reg <= underrun_next;
            end
            priority if (state_reg == ST_READ) begin
                state_reg   <= ST_IDLE;
                m_valid_reg <= 1'b1;
            end else if (fire && do_read) begin
                state_reg   <= ST_READ;
                m_valid_reg <= 1'b0;
            end else if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            op_drain_reg   <= (s_cmd == CMD_DRAIN_READ);
            hold_left_reg  <= s_left_in;
            hold_right_reg <= s_right_in;
        end
        if (state_reg == ST_READ) begin
            out_acc_reg      <= 1'b1;
            out_left_reg     <= conv_left;
            out_right_reg    <= conv_right;
            out_underrun_reg <= underrun_reg;
            out_level_reg    <= level_of(fill);
        end else if (fire && !do_read) begin
            out_acc_reg      <= acc;
            out_left_reg     <= res_left;
            out_right_reg    <= res_right;
            out_underrun_reg <= underrun_next;
            out_level_reg    <= level_of(fill_of(wr_ptr_next, rd_ptr_next));
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_accepted      = out_acc_reg;
    assign m_left_out      = out_left_reg;
    assign m_right_out     = out_right_reg;
    assign m_underrun_flag = out_underrun_reg;
    assign m_fill_level    = out_level_reg;

    a_read_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> !m_valid_reg)
        else $error("read result would overwrite a pending transfer");

    a_no_accept_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && do_read) |=> (state_reg == ST_READ && !s_ready))
        else $error("input taken while a memory read is in flight");

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && s_cmd == CMD_RESTART) |=>
            (wr_ptr_reg == '0 && rd_ptr_reg == '0 && !underrun_reg))
        else $error("restart did not clear pointers and underrun flag");

    a_full_push_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && fill == PTR_LAST && s_cmd != CMD_RESTART) |=> $stable(wr_ptr_reg))
        else $error("write pointer advanced on a full ring");

endmodule

### rtl/core/sfr_convert.sv
// ----------------------------------------------------------------------------
// sfr_convert
// Sample conversion on a frame read from the ring: saturating Q4.15 mix,
// or clamp to +-1.0 and scale by 32767 toward zero for drain.
// ----------------------------------------------------------------------------
module sfr_convert
    import sfr_pkg::*;
(
    input  logic                       is_drain,
    input  logic signed [SAMPLE_W-1:0] mix_left,
    input  logic signed [SAMPLE_W-1:0] mix_right,
    input  logic        [FRAME_W-1:0]  frame,
    output logic signed [SAMPLE_W-1:0] left_out,
    output logic signed [SAMPLE_W-1:0] right_out
);

    localparam logic signed [SAMPLE_W:0] SUM_MAX = (SAMPLE_W + 1)'(524287);
    localparam logic signed [SAMPLE_W:0] SUM_MIN = -(SAMPLE_W + 1)'(524288);
    localparam logic signed [SAMPLE_W-1:0] UNIT_POS = SAMPLE_W'(32768);
    localparam logic signed [SAMPLE_W-1:0] UNIT_NEG = -SAMPLE_W'(32768);
    localparam logic [14:0] SCALE_OUT = 15'd32767;

    function automatic logic signed [SAMPLE_W-1:0] sat_add(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b
    );
        logic signed [SAMPLE_W:0] s;
        s = (SAMPLE_W + 1)'(a) + (SAMPLE_W + 1)'(b);
        if (s > SUM_MAX) begin
            return SUM_MAX[SAMPLE_W-1:0];
        end else if (s < SUM_MIN) begin
            return SUM_MIN[SAMPLE_W-1:0];
        end
        return s[SAMPLE_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] to_int16(
        input logic signed [SAMPLE_W-1:0] q
    );
        logic signed [SAMPLE_W-1:0] v;
        logic        [15:0]         mag;
        logic        [30:0]         prod;
        logic        [15:0]         scaled;
        v = q;
        if (q > UNIT_POS) v = UNIT_POS;
        if (q < UNIT_NEG) v = UNIT_NEG;
        mag    = v[SAMPLE_W-1] ? 16'(-v) : 16'(v);
        prod   = 31'(mag) * 31'(SCALE_OUT);
        scaled = prod[30:15];
        return v[SAMPLE_W-1] ? -SAMPLE_W'(scaled) : SAMPLE_W'(scaled);
    endfunction

    logic signed [SAMPLE_W-1:0] frame_left;
    logic signed [SAMPLE_W-1:0] frame_right;

    assign frame_left  = frame[FRAME_W-1:SAMPLE_W];
    assign frame_right = frame[SAMPLE_W-1:0];

    always_comb begin
        if (is_drain) begin
            left_out  = to_int16(frame_left);
            right_out = to_int16(frame_right);
        end else begin
            left_out  = sat_add(mix_left, frame_left);
            right_out = sat_add(mix_right, frame_right);
        end
    end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stereo frame ring. A queue-fed driver sends
// commands over the s_ channel. A clocked monitor predicts each response
// from its own copy of the ring, pointers, underrun flag and registers, and
// checks every m_ transfer field by field. Phases run idle, playback (mono
// and stereo, ring filled to full with wrap-around), recording, the spare
// mode code and back to idle. Registers are written between phases, once the
// ring has gone quiet.
// ----------------------------------------------------------------------------
module testbench;
    import sfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_ALIAS  = 2'd3;
    localparam logic [1:0] REG_SPARE   = 2'd3;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    localparam int SAMPLE_HI = (1 << (SAMPLE_W - 1)) - 1;
    localparam int SAMPLE_LO = -(1 << (SAMPLE_W - 1));
    localparam int UNIT_Q15  = 32768;
    localparam int PCM_SCALE = 32767;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [2:0]          cmd;
        logic [SAMPLE_W-1:0] left_in;
        logic [SAMPLE_W-1:0] right_in;
        logic [BLOCK_W-1:0]  block_left;
    } ring_cmd_t;

    typedef struct packed {
        logic                accepted;
        logic [SAMPLE_W-1:0] left_out;
        logic [SAMPLE_W-1:0] right_out;
        logic                underrun_flag;
        logic [LEVEL_W-1:0]  fill_level;
    } ring_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [1:0] cfg_data = '0;

    logic      s_valid = 1'b0;
    logic      s_ready;
    ring_cmd_t on_wire = '0;

    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic                       m_accepted;
    logic signed [SAMPLE_W-1:0] m_left_out;
    logic signed [SAMPLE_W-1:0] m_right_out;
    logic                       m_underrun_flag;
    logic        [LEVEL_W-1:0]  m_fill_level;

    ring_cmd_t cmd_backlog[$];
    ring_out_t due_outputs[$];

    int queued_cnt = 0;
    int taken_cnt = 0;
    int done_cnt = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    logic in_fire = 1'b0;

    int         ring_l [RING_DEPTH];
    int         ring_r [RING_DEPTH];
    int         wr_idx = 0;
    int         rd_idx = 0;
    bit         underrun_seen = 1'b0;
    logic [1:0] cur_mode = MODE_IDLE;
    bit         cur_mono = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    stereo_frame_ring_with_conversion DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (on_wire.cmd),
        .s_left_in       (on_wire.left_in),
        .s_right_in      (on_wire.right_in),
        .s_block_left    (on_wire.block_left),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_accepted      (m_accepted),
        .m_left_out      (m_left_out),
        .m_right_out     (m_right_out),
        .m_underrun_flag (m_underrun_flag),
        .m_fill_level    (m_fill_level)
    );

    function automatic void store_frame(input int l, input int r);
        ring_l[wr_idx] = l;
        ring_r[wr_idx] = r;
        wr_idx = (wr_idx + 1) % RING_DEPTH;
    endfunction

    function automatic logic [SAMPLE_W-1:0] clip20(input int v);
        if (v > SAMPLE_HI) begin
            v = SAMPLE_HI;
        end else if (v < SAMPLE_LO) begin
            v = SAMPLE_LO;
        end
        return SAMPLE_W'(v);
    endfunction

    function automatic logic [SAMPLE_W-1:0] to_pcm16(input int q);
        longint mag;
        if (q > UNIT_Q15) begin
            q = UNIT_Q15;
        end else if (q < -UNIT_Q15) begin
            q = -UNIT_Q15;
        end
        mag = (longint'(q < 0 ? -q : q) * PCM_SCALE) >>> 15;
        return SAMPLE_W'(q < 0 ? -mag : mag);
    endfunction

    function automatic ring_out_t apply_command(input ring_cmd_t c);
        ring_out_t o;
        int fill;
        int span;
        int l;
        int r;
        o = '0;
        fill = (wr_idx - rd_idx + RING_DEPTH) % RING_DEPTH;
        span = (c.block_left == '0) ? 1 : int'(c.block_left);
        case (c.cmd)
            CMD_FILE_PUSH: begin
                if (cur_mode == MODE_PLAY && fill < RING_DEPTH - 1) begin
                    l = $signed(c.left_in[15:0]);
                    r = cur_mono ? l : $signed(c.right_in[15:0]);
                    store_frame(l, r);
                    o.accepted = 1'b1;
                end
            end
            CMD_MIX_READ: begin
                o.left_out = c.left_in;
                o.right_out = c.right_in;
                if (cur_mode == MODE_PLAY) begin
                    if (fill == 0) begin
                        underrun_seen = 1'b1;
                    end else begin
                        o.left_out = clip20($signed(c.left_in) + ring_l[rd_idx]);
                        o.right_out = clip20($signed(c.right_in) + ring_r[rd_idx]);
                        rd_idx = (rd_idx + 1) % RING_DEPTH;
                        o.accepted = 1'b1;
                    end
                end
            end
            CMD_RECORD_PUSH: begin
                if (cur_mode == MODE_RECORD && RING_DEPTH - 1 - fill >= span) begin
                    store_frame($signed(c.left_in), $signed(c.right_in));
                    o.accepted = 1'b1;
                end
            end
            CMD_DRAIN_READ: begin
                if (cur_mode == MODE_RECORD && fill > 0) begin
                    o.left_out = to_pcm16(ring_l[rd_idx]);
                    o.right_out = to_pcm16(ring_r[rd_idx]);
                    rd_idx = (rd_idx + 1) % RING_DEPTH;
                    o.accepted = 1'b1;
                end
            end
            CMD_RESTART: begin
                wr_idx = 0;
                rd_idx = 0;
                underrun_seen = 1'b0;
            end
            default: begin
            end
        endcase
        o.underrun_flag = underrun_seen;
        o.fill_level = LEVEL_W'((wr_idx - rd_idx + RING_DEPTH) % RING_DEPTH);
        return o;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [SAMPLE_W-1:0] want,
                                        input logic [SAMPLE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            mismatches++;
        end
    endfunction

    function automatic bit take_break(input int n);
        if (n >= 500 && n < 800) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 12;
    endfunction

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || in_fire) begin
                if (cmd_backlog.size() > 0 && !take_break(taken_cnt)) begin
                    on_wire <= cmd_backlog.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= !take_break(done_cnt);
        end
    end

    always @(posedge aclk) begin : response_check
        ring_out_t want;
        if (!aresetn) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                due_outputs.push_back(apply_command(on_wire));
                taken_cnt++;
            end
            if (m_valid && m_ready) begin
                if (due_outputs.size() == 0) begin
                    $error("output transfer with no command pending");
                    mismatches++;
                end else begin
                    want = due_outputs.pop_front();
                    check_field("accepted", want.accepted, m_accepted);
                    check_field("left_out", want.left_out, m_left_out);
                    check_field("right_out", want.right_out, m_right_out);
                    check_field("underrun_flag", want.underrun_flag, m_underrun_flag);
                    check_field("fill_level", want.fill_level, m_fill_level);
                end
                done_cnt++;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    task automatic add_cmd(input logic [2:0] cmd, input logic [SAMPLE_W-1:0] l,
                           input logic [SAMPLE_W-1:0] r, input logic [BLOCK_W-1:0] blk);
        cmd_backlog.push_back('{cmd, l, r, blk});
        queued_cnt++;
    endtask

    task automatic add_noise();
        add_cmd(3'($urandom_range(CMD_FILE_PUSH, CMD_SPARE_HI)), SAMPLE_W'($urandom),
                SAMPLE_W'($urandom), BLOCK_W'($urandom));
    endtask

    // hold until every transfer is back, then let the pipeline drain
    task automatic settle();
        wait (taken_cnt == queued_cnt && done_cnt == queued_cnt);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_MODE) begin
            cur_mode = val;
        end else if (idx == REG_MONO) begin
            cur_mono = val[0];
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return SAMPLE_W'(SAMPLE_HI);
            1: return SAMPLE_W'(SAMPLE_LO);
            2: return SAMPLE_W'(UNIT_Q15 - 1 + int'($urandom_range(0, 2)));
            3: return SAMPLE_W'(-(UNIT_Q15 - 1 + int'($urandom_range(0, 2))));
            4: return SAMPLE_W'(int'($urandom_range(0, 2047)) - 1024);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_pcm();
        case ($urandom_range(0, 3))
            0: return {4'($urandom), 16'h7FFF};
            1: return {4'($urandom), 16'h8000};
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial begin
        int n;
        int k;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int c = CMD_FILE_PUSH; c <= CMD_SPARE_HI; c++) begin
            add_cmd(3'(c), SAMPLE_W'(SAMPLE_HI), SAMPLE_W'(SAMPLE_LO), BLOCK_W'(1));
        end
        settle();

        write_reg(REG_MODE, MODE_PLAY);
        add_cmd(CMD_MIX_READ, SAMPLE_W'(SAMPLE_HI), SAMPLE_W'(SAMPLE_LO), BLOCK_W'(1));
        add_cmd(CMD_FILE_PUSH, {4'hA, 16'h7FFF}, {4'h5, 16'h8000}, BLOCK_W'(1));
        add_cmd(CMD_FILE_PUSH, {4'h3, 16'h8000}, {4'hC, 16'h7FFF}, BLOCK_W'(1));
        add_cmd(CMD_MIX_READ, SAMPLE_W'(SAMPLE_HI), SAMPLE_W'(SAMPLE_LO), BLOCK_W'(1));
        add_cmd(CMD_MIX_READ, SAMPLE_W'(SAMPLE_LO), SAMPLE_W'(SAMPLE_HI), BLOCK_W'(1));
        add_cmd(CMD_RESTART, '0, '0, BLOCK_W'(1));
        settle();

        write_reg(REG_MONO, 2'b01);
        add_cmd(CMD_FILE_PUSH, {4'hF, 16'h1234}, 20'h0ABCD, BLOCK_W'(1));
        add_cmd(CMD_MIX_READ, '0, '0, BLOCK_W'(1));
        settle();

        write_reg(REG_MODE, MODE_RECORD);
        add_cmd(CMD_RECORD_PUSH, SAMPLE_W'(UNIT_Q15), SAMPLE_W'(-UNIT_Q15), '0);
        add_cmd(CMD_RECORD_PUSH, SAMPLE_W'(SAMPLE_HI), SAMPLE_W'(SAMPLE_LO), BLOCK_W'(RING_DEPTH));
        add_cmd(CMD_RECORD_PUSH, SAMPLE_W'(SAMPLE_HI), SAMPLE_W'(SAMPLE_LO), '1);
        add_cmd(CMD_RECORD_PUSH, SAMPLE_W'(SAMPLE_HI), SAMPLE_W'(SAMPLE_LO), BLOCK_W'(1));
        add_cmd(CMD_RECORD_PUSH, SAMPLE_W'(UNIT_Q15 + 1), SAMPLE_W'(-UNIT_Q15 - 1),
                BLOCK_W'(2));
        repeat (4) add_cmd(CMD_DRAIN_READ, '0, '0, BLOCK_W'(1));
        settle();

        write_reg(REG_MODE, MODE_PLAY);
        for (int m = 0; m < 2; m++) begin
            write_reg(REG_MONO, {1'($urandom), 1'(m)});
            repeat (8) begin
                n = $urandom_range(1, 12);
                repeat (n) add_cmd(CMD_FILE_PUSH, pick_pcm(), pick_pcm(), BLOCK_W'($urandom));
                n = $urandom_range(1, 14);
                repeat (n) add_cmd(CMD_MIX_READ, pick_sample(), pick_sample(),
                                   BLOCK_W'($urandom));
                if ($urandom_range(0, 9) == 0) begin
                    add_noise();
                end
            end
            settle();
        end

        // fill to full, refuse, then wrap the write pointer
        write_reg(REG_MONO, 2'($urandom));
        add_cmd(CMD_RESTART, '0, '0, BLOCK_W'(1));
        repeat (RING_DEPTH + 1) add_cmd(CMD_FILE_PUSH, pick_pcm(), pick_pcm(), BLOCK_W'($urandom));
        repeat (3) add_cmd(CMD_MIX_READ, pick_sample(), pick_sample(), BLOCK_W'($urandom));
        repeat (5) add_cmd(CMD_FILE_PUSH, pick_pcm(), pick_pcm(), BLOCK_W'($urandom));
        repeat (20) begin
            if ($urandom_range(0, 1) == 0) begin
                add_cmd(CMD_FILE_PUSH, pick_pcm(), pick_pcm(), BLOCK_W'($urandom));
            end else begin
                add_cmd(CMD_MIX_READ, pick_sample(), pick_sample(), BLOCK_W'($urandom));
            end
        end
        settle();

        write_reg(REG_MODE, MODE_RECORD);
        repeat (3) add_cmd(CMD_DRAIN_READ, pick_sample(), pick_sample(), BLOCK_W'($urandom));
        add_cmd(CMD_RESTART, '0, '0, BLOCK_W'(1));
        repeat (12) begin
            n = $urandom_range(1, 12);
            for (int i = n; i > 0; i--) begin
                add_cmd(CMD_RECORD_PUSH, pick_sample(), pick_sample(), BLOCK_W'(i));
            end
            case ($urandom_range(0, 5))
                0: add_cmd(CMD_RECORD_PUSH, pick_sample(), pick_sample(),
                           BLOCK_W'($urandom_range(RING_DEPTH, 2047)));
                1: add_cmd(CMD_RECORD_PUSH, pick_sample(), pick_sample(), '0);
                2: add_noise();
                default: begin
                end
            endcase
            k = $urandom_range(1, n + 4);
            repeat (k) add_cmd(CMD_DRAIN_READ, pick_sample(), pick_sample(), BLOCK_W'($urandom));
        end
        settle();

        write_reg(REG_MODE, MODE_ALIAS);
        write_reg(REG_MONO, 2'($urandom));
        write_reg(REG_SPARE, 2'b11);
        repeat (20) add_noise();
        settle();

        write_reg(REG_MODE, MODE_IDLE);
        repeat (10) add_noise();
        settle();

        if (mismatches == 0 && due_outputs.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
